@@ rtl/core/rcfd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfd_pkg
// Types and constants shared by the RC serial frame decoder modules.
// ----------------------------------------------------------------------------
package rcfd_pkg;

  localparam int STORE_DEPTH_DEF = 64;

  typedef enum logic [1:0] {
    PROTO_NONE = 2'd0,
    PROTO_SBUS = 2'd1,
    PROTO_IBUS = 2'd2,
    PROTO_CRSF = 2'd3
  } proto_t;

  localparam logic CFG_PROTOCOL = 1'b0;
  localparam logic CFG_GAP      = 1'b1;

  localparam logic [7:0] SBUS_START   = 8'h0F;
  localparam logic [6:0] SBUS_LEN     = 7'd25;
  localparam logic [6:0] SBUS_FLAGS   = 7'd23;
  localparam logic [7:0] IBUS_HEADER  = 8'h20;
  localparam logic [6:0] IBUS_LEN     = 7'd32;
  localparam logic [6:0] IBUS_CSUM_LO = 7'd30;
  localparam logic [7:0] CRSF_SYNC    = 8'hC8;
  localparam logic [7:0] CRSF_RC_TYPE = 8'h16;
  localparam logic [7:0] CRSF_MIN_LEN = 8'd2;
  localparam logic [7:0] CRSF_MAX_LEN = 8'd62;
  localparam logic [7:0] CRSF_RC_MIN  = 8'd24;
  localparam logic [6:0] CRSF_TYPE_AT = 7'd2;
  localparam logic [15:0] CH_OFFSET   = 16'd880;
  localparam logic [8:0] IDLE_MAX     = 9'd511;

  localparam logic [4:0] BASE_SBUS = 5'd1;
  localparam logic [4:0] BASE_IBUS = 5'd2;
  localparam logic [4:0] BASE_CRSF = 5'd3;
  localparam logic [4:0] W_NARROW  = 5'd11;
  localparam logic [4:0] W_WIDE    = 5'd16;
  localparam logic [3:0] LAST_NARROW = 4'd15;
  localparam logic [3:0] LAST_WIDE   = 4'd13;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_ACC  = 2'd2,
    ST_EMIT = 2'd3
  } state_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [3:0]  channel_index;
    logic [15:0] channel_value;
    logic [7:0]  sbus_flags;
    logic        last;
  } out_t;

  typedef struct packed {
    logic take;
    logic rd;
    logic acc;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic frame_go;
    logic have_ch;
    logic last_ch;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/core/rc_serial_frame_decoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_serial_frame_decoder_top
// Decodes SBUS, iBUS or CRSF RC frames from received bytes into channels.
// ----------------------------------------------------------------------------
// Each input beat is a received byte or a 1 ms tick, taken only while idle.
// The beat completing a good frame starts unpacking: channels are read from
// the frame store one byte per read (one read port, registered), so a frame
// yields its 16 (or 14 iBUS) result beats: bytes are read and accumulated,
// and a channel is emitted once enough bits are held and the output is free,
// no beat is taken meanwhile. Result beats are held in an output register.
module rc_serial_frame_decoder_top #(
  parameter int STORE_DEPTH = rcfd_pkg::STORE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  rcfd_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output rcfd_pkg::out_t  out_data,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [7:0]      cfg_wdata
);

  rcfd_pkg::cmd_t cmd;
  rcfd_pkg::sts_t sts;

  rcfd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rcfd_dp #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

@@ rtl/core/rcfd_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfd_ctrl
// Sequencer: takes beats and walks channel unpacking of a finished frame.
// ----------------------------------------------------------------------------
module rcfd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  rcfd_pkg::sts_t  sts,
  output rcfd_pkg::cmd_t  cmd
);

  rcfd_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rcfd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rcfd_pkg::ST_IDLE: begin
        if (in_valid && sts.frame_go) state_nxt = rcfd_pkg::ST_READ;
      end
      rcfd_pkg::ST_READ: state_nxt = rcfd_pkg::ST_ACC;
      rcfd_pkg::ST_ACC:  state_nxt = rcfd_pkg::ST_EMIT;
      rcfd_pkg::ST_EMIT: begin
        if (!sts.have_ch) begin
          state_nxt = rcfd_pkg::ST_READ;
        end else if (sts.out_free) begin
          state_nxt = sts.last_ch ? rcfd_pkg::ST_IDLE : rcfd_pkg::ST_READ;
        end
      end
      default: state_nxt = rcfd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      rcfd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      rcfd_pkg::ST_READ: cmd.rd  = 1'b1;
      rcfd_pkg::ST_ACC:  cmd.acc = 1'b1;
      rcfd_pkg::ST_EMIT: cmd.emit = sts.have_ch && sts.out_free;
      default: ;
    endcase
  end

endmodule

@@ rtl/core/rcfd_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfd_dp
// Frame parser, frame byte store, channel unpacker and result register.
// ----------------------------------------------------------------------------
module rcfd_dp #(
  parameter int STORE_DEPTH = rcfd_pkg::STORE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  rcfd_pkg::in_t   in_data,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [7:0]      cfg_wdata,
  input  logic            out_ready,
  output logic            out_valid,
  output rcfd_pkg::out_t  out_data,
  input  rcfd_pkg::cmd_t  cmd,
  output rcfd_pkg::sts_t  sts
);

  localparam int AW = $clog2(STORE_DEPTH);

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rd_data_r;

  rcfd_pkg::proto_t proto_r, proto_nxt;
  logic [7:0]  gap_r, gap_nxt;
  logic [6:0]  pos_r, pos_nxt, pos_eff, np;
  logic [7:0]  len_r, len_nxt, type_r, type_nxt, side_r, side_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [8:0]  idle_r, idle_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic        wr_en, go, hit, gap_hit;
  logic [7:0]  b, hdr;
  logic [4:0]  base;

  logic [23:0] acc_r;
  logic [4:0]  cnt_r, rd_addr_r, wdt;
  logic [3:0]  ch_r;
  logic        wide_r, out_valid_r;
  rcfd_pkg::out_t out_r;

  assign b       = in_data.data_byte;
  assign gap_hit = (proto_r == rcfd_pkg::PROTO_IBUS) && (idle_r > {1'b0, gap_r});
  assign pos_eff = gap_hit ? 7'd0 : pos_r;
  assign np      = pos_eff + 7'd1;

  always_comb begin
    unique case (proto_r)
      rcfd_pkg::PROTO_SBUS: hdr = rcfd_pkg::SBUS_START;
      rcfd_pkg::PROTO_IBUS: hdr = rcfd_pkg::IBUS_HEADER;
      default:              hdr = rcfd_pkg::CRSF_SYNC;
    endcase
  end

  assign hit = (pos_eff != 7'd0) || (b == hdr);

  always_comb begin
    proto_nxt = proto_r;
    gap_nxt   = gap_r;
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    type_nxt  = type_r;
    side_nxt  = side_r;
    flags_nxt = flags_r;
    idle_nxt  = idle_r;
    sum_nxt   = sum_r;
    wr_en     = 1'b0;
    go        = 1'b0;
    base      = rcfd_pkg::BASE_SBUS;
    if (cmd.take && in_data.cmd) begin
      if (idle_r != rcfd_pkg::IDLE_MAX) idle_nxt = idle_r + 9'd1;
    end else if (cmd.take) begin
      unique case (proto_r)
        rcfd_pkg::PROTO_SBUS: begin
          if (hit) begin
            wr_en   = 1'b1;
            pos_nxt = np;
            if (pos_eff == rcfd_pkg::SBUS_FLAGS) side_nxt = b;
            if (np == rcfd_pkg::SBUS_LEN) begin
              pos_nxt = 7'd0;
              if (b == 8'd0) begin
                flags_nxt = side_r;
                go        = 1'b1;
              end
            end
          end
        end
        rcfd_pkg::PROTO_IBUS: begin
          idle_nxt = '0;
          pos_nxt  = pos_eff;
          base     = rcfd_pkg::BASE_IBUS;
          if (hit) begin
            wr_en   = 1'b1;
            pos_nxt = np;
            if (pos_eff == 7'd0) begin
              sum_nxt = 16'hFFFF - {8'd0, b};
            end else if (pos_eff < rcfd_pkg::IBUS_CSUM_LO) begin
              sum_nxt = sum_r - {8'd0, b};
            end
            if (pos_eff == rcfd_pkg::IBUS_CSUM_LO) side_nxt = b;
            if (np == rcfd_pkg::IBUS_LEN) begin
              pos_nxt = 7'd0;
              go      = (sum_r == {b, side_r});
            end
          end
        end
        rcfd_pkg::PROTO_CRSF: begin
          base = rcfd_pkg::BASE_CRSF;
          if (hit) begin
            wr_en   = 1'b1;
            pos_nxt = np;
            if (pos_eff == rcfd_pkg::CRSF_TYPE_AT) type_nxt = b;
            if (np == 7'd2) begin
              len_nxt = b;
              if (b < rcfd_pkg::CRSF_MIN_LEN || b > rcfd_pkg::CRSF_MAX_LEN) pos_nxt = 7'd0;
            end
            if (np > 7'd2 && {2'b0, np} == ({1'b0, len_r} + 9'd2)) begin
              pos_nxt = 7'd0;
              go = (type_r == rcfd_pkg::CRSF_RC_TYPE) && (len_r >= rcfd_pkg::CRSF_RC_MIN);
            end
          end
        end
        default: ;
      endcase
    end
    if (cfg_we) begin
      case (cfg_index)
        rcfd_pkg::CFG_PROTOCOL: begin
          proto_nxt = rcfd_pkg::proto_t'(cfg_wdata[1:0]);
          pos_nxt   = 7'd0;
        end
        rcfd_pkg::CFG_GAP: gap_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proto_r <= rcfd_pkg::PROTO_NONE;
      gap_r   <= 8'd10;
      pos_r   <= '0;
      len_r   <= '0;
      flags_r <= '0;
      idle_r  <= '0;
    end else begin
      proto_r <= proto_nxt;
      gap_r   <= gap_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      flags_r <= flags_nxt;
      idle_r  <= idle_nxt;
    end
  end

  always_ff @(posedge clk) begin
    type_r <= type_nxt;
    side_r <= side_nxt;
    sum_r  <= sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en && ({2'b0, pos_eff} < 9'(STORE_DEPTH))) mem[AW'(pos_eff)] <= b;
    if (cmd.rd) rd_data_r <= mem[AW'(rd_addr_r)];
  end

  assign wdt = wide_r ? rcfd_pkg::W_WIDE : rcfd_pkg::W_NARROW;

  always_ff @(posedge clk) begin
    if (cmd.take && go) begin
      acc_r     <= '0;
      cnt_r     <= '0;
      ch_r      <= '0;
      rd_addr_r <= base;
      wide_r    <= (proto_r == rcfd_pkg::PROTO_IBUS);
    end else begin
      if (cmd.rd) rd_addr_r <= rd_addr_r + 5'd1;
      if (cmd.acc) begin
        acc_r <= acc_r | ({16'd0, rd_data_r} << cnt_r);
        cnt_r <= cnt_r + 5'd8;
      end
      if (cmd.emit) begin
        acc_r <= wide_r ? (acc_r >> 16) : (acc_r >> 11);
        cnt_r <= cnt_r - wdt;
        ch_r  <= ch_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.channel_index <= ch_r;
      out_r.channel_value <= wide_r ? acc_r[15:0] : ({5'd0, acc_r[10:0]} + rcfd_pkg::CH_OFFSET);
      out_r.sbus_flags    <= flags_r;
      out_r.last          <= sts.last_ch;
    end
  end

  assign sts.frame_go = go;
  assign sts.have_ch  = (cnt_r >= wdt);
  assign sts.last_ch  = (ch_r == (wide_r ? rcfd_pkg::LAST_WIDE : rcfd_pkg::LAST_NARROW));
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready)) else $error("result overwritten");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc |-> (cnt_r < 5'd16)) else $error("unpack bit count overflow");
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r < 7'd64) else $error("byte position out of range");
  a_emit_go: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take && go) |=> !cmd.emit) else $error("emit right after frame start");

endmodule
